FILE: hw/rtl/tslf_pkg.sv
// ----------------------------------------------------------------------------
// tslf_pkg
// Shared types, constants and codepoint classifiers for the Thai syllable
// length finder.
// ----------------------------------------------------------------------------
package tslf_pkg;

  // Widths of the result length and codepoint fields, and the default length limit.
  localparam int unsigned SylW          = 11;
  localparam int unsigned CpW           = 21;
  localparam int unsigned MaxBytesDflt  = 1024;

  typedef enum logic [2:0] {
    PhStart   = 3'd0,
    PhLead    = 3'd1,
    PhOnset   = 3'd2,
    PhMarks   = 3'd3,
    PhDone    = 3'd4,
    PhInvalid = 3'd5
  } phase_e;

  typedef logic [CpW-1:0] cp_t;

  localparam cp_t CpLeadLo    = 21'h00E40;
  localparam cp_t CpLeadHi    = 21'h00E44;
  localparam cp_t CpConsLo    = 21'h00E01;
  localparam cp_t CpConsHi    = 21'h00E2E;
  localparam cp_t CpClusYo    = 21'h00E22;
  localparam cp_t CpClusRo    = 21'h00E23;
  localparam cp_t CpClusLo    = 21'h00E25;
  localparam cp_t CpClusWo    = 21'h00E27;
  localparam cp_t CpVowelA    = 21'h00E30;
  localparam cp_t CpVowelAa   = 21'h00E32;
  localparam cp_t CpVowelAm   = 21'h00E33;
  localparam cp_t CpMarkHan   = 21'h00E31;
  localparam cp_t CpMarkALo   = 21'h00E34;
  localparam cp_t CpMarkAHi   = 21'h00E3A;
  localparam cp_t CpMarkBLo   = 21'h00E47;
  localparam cp_t CpMarkBHi   = 21'h00E4E;

  function automatic logic is_lead_vowel(cp_t c);
    return (c >= CpLeadLo) && (c <= CpLeadHi);
  endfunction

  function automatic logic is_consonant(cp_t c);
    return (c >= CpConsLo) && (c <= CpConsHi);
  endfunction

  function automatic logic is_cluster(cp_t c);
    return (c == CpClusYo) || (c == CpClusRo) || (c == CpClusLo) || (c == CpClusWo);
  endfunction

  function automatic logic is_mark(cp_t c);
    return (c == CpMarkHan) || ((c >= CpMarkALo) && (c <= CpMarkAHi)) ||
           ((c >= CpMarkBLo) && (c <= CpMarkBHi));
  endfunction

  function automatic logic is_spacing_vowel(cp_t c);
    return (c == CpVowelA) || (c == CpVowelAa) || (c == CpVowelAm);
  endfunction

endpackage

FILE: hw/rtl/thai_syllable_length_finder_unit.sv
// ----------------------------------------------------------------------------
// thai_syllable_length_finder_unit
// Decodes a UTF-8 byte stream and reports the byte length of the first Thai
// syllable of each buffer.
// ----------------------------------------------------------------------------
// The block takes one byte item per cycle while its input is not stalled: the
// UTF-8 decoder and the syllable grammar update their state in a single pass
// from the accepted byte. When the byte flagged last_byte_i is taken, the
// result item appears on the next cycle in an output register and the parse
// state returns to its start, so the next buffer may begin at once. Bytes in
// the middle of a buffer produce no result item. A length above MAX_BYTES is
// reported as MAX_BYTES with too_long_o set. Input is stalled only while a
// result item waits and the output side stalls.
module thai_syllable_length_finder_unit #(
  parameter int unsigned MAX_BYTES = tslf_pkg::MaxBytesDflt
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [7:0]                byte_value_i,
  input  logic                      last_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [tslf_pkg::SylW-1:0] syllable_bytes_o,
  output logic                      too_long_o
);

  // The byte counter must hold MAX_BYTES + 1.
  localparam int unsigned CntW = $clog2(MAX_BYTES + 2);
  localparam int unsigned ExtW = (CntW > tslf_pkg::SylW) ? CntW : tslf_pkg::SylW;

  tslf_pkg::phase_e  phase_q, phase_d;
  tslf_pkg::cp_t     partial_q, partial_d;
  logic [1:0]        cont_q, cont_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   end_q, end_d;
  logic              vowel_q, vowel_d;
  logic              cluster_q, cluster_d;

  logic              out_valid_q, out_valid_d;
  logic [tslf_pkg::SylW-1:0] syl_q, syl_d;
  logic              long_q, long_d;

  logic              accept;
  logic              take_cp;
  tslf_pkg::cp_t     cp;
  tslf_pkg::phase_e  phase_n;
  logic [CntW-1:0]   end_n;
  logic              vowel_n;
  logic              cluster_n;
  logic [CntW-1:0]   len;
  logic [ExtW-1:0]   len_ext;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // UTF-8 decode: produces at most one complete codepoint per byte.
  always_comb begin
    partial_d = partial_q;
    cont_d    = cont_q;
    cnt_d     = cnt_q;
    take_cp   = 1'b0;
    cp        = '0;
    if (phase_q != tslf_pkg::PhDone && phase_q != tslf_pkg::PhInvalid) begin
      if (cnt_q <= CntW'(MAX_BYTES)) begin
        cnt_d = cnt_q + CntW'(1);
      end
      if (cont_q == 2'd0) begin
        priority if (byte_value_i[7] == 1'b0) begin
          take_cp = 1'b1;
          cp      = tslf_pkg::cp_t'(byte_value_i);
        end else if (byte_value_i[7:5] == 3'b110) begin
          partial_d = tslf_pkg::cp_t'(byte_value_i[4:0]);
          cont_d    = 2'd1;
        end else if (byte_value_i[7:4] == 4'b1110) begin
          partial_d = tslf_pkg::cp_t'(byte_value_i[3:0]);
          cont_d    = 2'd2;
        end else if (byte_value_i[7:3] == 5'b11110) begin
          partial_d = tslf_pkg::cp_t'(byte_value_i[2:0]);
          cont_d    = 2'd3;
        end else begin
          // Stray continuation byte or invalid lead byte.
          take_cp = 1'b1;
        end
      end else if (byte_value_i[7:6] != 2'b10) begin
        // A missing continuation counts as a bad codepoint; the byte is lost.
        partial_d = '0;
        cont_d    = 2'd0;
        take_cp   = 1'b1;
      end else begin
        partial_d = {partial_q[tslf_pkg::CpW-7:0], byte_value_i[5:0]};
        cont_d    = cont_q - 2'd1;
        if (cont_q == 2'd1) begin
          take_cp = 1'b1;
          cp      = {partial_q[tslf_pkg::CpW-7:0], byte_value_i[5:0]};
        end
      end
    end
  end

  // Syllable grammar on the decoded codepoint. A bad codepoint arrives as 0.
  always_comb begin
    phase_n   = phase_q;
    end_n     = end_q;
    vowel_n   = vowel_q;
    cluster_n = cluster_q;
    if (take_cp) begin
      unique case (phase_q)
        tslf_pkg::PhStart: begin
          priority if (tslf_pkg::is_lead_vowel(cp)) begin
            vowel_n = 1'b1;
            phase_n = tslf_pkg::PhLead;
          end else if (tslf_pkg::is_consonant(cp)) begin
            end_n   = cnt_d;
            phase_n = tslf_pkg::PhOnset;
          end else begin
            phase_n = tslf_pkg::PhInvalid;
          end
        end
        tslf_pkg::PhLead: begin
          if (tslf_pkg::is_consonant(cp)) begin
            end_n   = cnt_d;
            phase_n = tslf_pkg::PhOnset;
          end else begin
            phase_n = tslf_pkg::PhInvalid;
          end
        end
        tslf_pkg::PhOnset, tslf_pkg::PhMarks: begin
          phase_n = tslf_pkg::PhMarks;
          priority if (phase_q == tslf_pkg::PhOnset && tslf_pkg::is_cluster(cp)) begin
            end_n     = cnt_d;
            cluster_n = 1'b1;
          end else if (cp == '0) begin
            phase_n = tslf_pkg::PhInvalid;
          end else if (tslf_pkg::is_mark(cp)) begin
            end_n = cnt_d;
          end else if (tslf_pkg::is_spacing_vowel(cp)) begin
            end_n   = cnt_d;
            vowel_n = 1'b1;
          end else begin
            // Implicit coda: only without a vowel, and a cluster letter
            // only after a cluster.
            if (!vowel_q && tslf_pkg::is_consonant(cp) &&
                (cluster_q || !tslf_pkg::is_cluster(cp))) begin
              end_n = cnt_d;
            end
            phase_n = tslf_pkg::PhDone;
          end
        end
        default: begin
          phase_n = phase_q;
        end
      endcase
    end
  end

  // Result formation on the last byte, and state return to start.
  always_comb begin
    phase_d     = phase_q;
    end_d       = end_q;
    vowel_d     = vowel_q;
    cluster_d   = cluster_q;
    out_valid_d = out_valid_q && out_stall_i;
    syl_d       = syl_q;
    long_d      = long_q;
    len         = '0;
    if (phase_n == tslf_pkg::PhOnset || phase_n == tslf_pkg::PhMarks ||
        phase_n == tslf_pkg::PhDone) begin
      len = end_n;
    end
    long_d = long_q;
    if (len > CntW'(MAX_BYTES)) begin
      len_ext = ExtW'(MAX_BYTES);
    end else begin
      len_ext = ExtW'(len);
    end
    if (accept) begin
      phase_d   = phase_n;
      end_d     = end_n;
      vowel_d   = vowel_n;
      cluster_d = cluster_n;
      if (last_byte_i) begin
        out_valid_d = 1'b1;
        syl_d       = len_ext[tslf_pkg::SylW-1:0];
        long_d      = (len > CntW'(MAX_BYTES));
        phase_d     = tslf_pkg::PhStart;
        end_d       = '0;
        vowel_d     = 1'b0;
        cluster_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= tslf_pkg::PhStart;
      partial_q   <= '0;
      cont_q      <= 2'd0;
      cnt_q       <= '0;
      end_q       <= '0;
      vowel_q     <= 1'b0;
      cluster_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      end_q       <= end_d;
      vowel_q     <= vowel_d;
      cluster_q   <= cluster_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        if (last_byte_i) begin
          partial_q <= '0;
          cont_q    <= 2'd0;
          cnt_q     <= '0;
        end else begin
          partial_q <= partial_d;
          cont_q    <= cont_d;
          cnt_q     <= cnt_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    syl_q  <= syl_d;
    long_q <= long_d;
  end

  assign out_valid_o      = out_valid_q;
  assign syllable_bytes_o = syl_q;
  assign too_long_o       = long_q;

endmodule

FILE: hw/rtl/tslf_checker.sv
// ----------------------------------------------------------------------------
// tslf_checker
// Port-level checks for the Thai syllable length finder, bound to the top.
// ----------------------------------------------------------------------------
module tslf_checker #(
  parameter int unsigned MAX_BYTES = tslf_pkg::MaxBytesDflt
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      last_byte_i,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [tslf_pkg::SylW-1:0] syllable_bytes_o,
  input logic                      too_long_o
);

  logic in_acc;
  logic out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // A stalled result item holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(syllable_bytes_o) &&
    $stable(too_long_o))
    else $error("result item changed while stalled");

  // The last byte of a buffer yields a result item on the next cycle.
  a_last_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && last_byte_i |=> out_valid_o)
    else $error("no result item after last byte");

  // A result item only follows a last byte.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_acc) && !(in_acc && last_byte_i) |=> !out_valid_o)
    else $error("result item without last byte");

  // The input is held off only while a result item is stalled.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a waiting result item");

  // A saturated length reads as the limit.
  a_saturate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && too_long_o |-> syllable_bytes_o == tslf_pkg::SylW'(MAX_BYTES))
    else $error("too_long set with a length other than the limit");

endmodule

bind thai_syllable_length_finder_unit tslf_checker #(
  .MAX_BYTES(MAX_BYTES)
) u_tslf_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .last_byte_i      (last_byte_i),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .syllable_bytes_o (syllable_bytes_o),
  .too_long_o       (too_long_o)
);

FILE: test/thai_syllable_length_finder_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thai syllable length checker
// Watches both channels of the syllable length finder. It keeps its own
// UTF-8 decoder and syllable grammar and queues the length that each buffer
// should report. Every result item taken from the block is compared with the
// oldest queued length.
// ----------------------------------------------------------------------------
module thai_syllable_length_finder_checker
  import tslf_pkg::*;
#(
  parameter int unsigned MAX_BYTES = MaxBytesDflt
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_stall_i,
  input  logic [7:0]      byte_value_i,
  input  logic            last_byte_i,
  input  logic            out_valid_i,
  input  logic            out_stall_i,
  input  logic [SylW-1:0] syllable_bytes_i,
  input  logic            too_long_i,
  output int              pending_o,
  output int              mismatches_o
);

  typedef enum logic [2:0] {
    ClsNull,
    ClsLeadVowel,
    ClsPlainCons,
    ClsClusterCons,
    ClsMark,
    ClsSpacingVowel,
    ClsOther
  } cp_class_e;

  typedef struct packed {
    logic [SylW-1:0] nbytes;
    logic            too_long;
  } syl_len_t;

  syl_len_t    syl_len_q[$];

  phase_e      phase;
  cp_t         partial_cp;
  int unsigned cont_left;
  int unsigned consumed;
  int unsigned syl_end;
  bit          has_vowel;
  bit          has_cluster;

  function automatic cp_class_e classify_cp(cp_t c);
    if (c == '0) return ClsNull;
    if (c >= CpLeadLo && c <= CpLeadHi) return ClsLeadVowel;
    if (c == CpClusYo || c == CpClusRo || c == CpClusLo || c == CpClusWo) begin
      return ClsClusterCons;
    end
    if (c >= CpConsLo && c <= CpConsHi) return ClsPlainCons;
    if (c == CpMarkHan || (c >= CpMarkALo && c <= CpMarkAHi) ||
        (c >= CpMarkBLo && c <= CpMarkBHi)) begin
      return ClsMark;
    end
    if (c == CpVowelA || c == CpVowelAa || c == CpVowelAm) return ClsSpacingVowel;
    return ClsOther;
  endfunction

  function automatic void clear_parse();
    phase       = PhStart;
    partial_cp  = '0;
    cont_left   = 0;
    consumed    = 0;
    syl_end     = 0;
    has_vowel   = 1'b0;
    has_cluster = 1'b0;
  endfunction

  function automatic void parse_codepoint(cp_t c);
    cp_class_e k;
    k = classify_cp(c);
    case (phase)
      PhStart: begin
        if (k == ClsLeadVowel) begin
          // A lead vowel rules out an implicit coda later on.
          has_vowel = 1'b1;
          phase     = PhLead;
        end else if (k == ClsPlainCons || k == ClsClusterCons) begin
          syl_end = consumed;
          phase   = PhOnset;
        end else begin
          phase = PhInvalid;
        end
        return;
      end
      PhLead: begin
        if (k == ClsPlainCons || k == ClsClusterCons) begin
          syl_end = consumed;
          phase   = PhOnset;
        end else begin
          phase = PhInvalid;
        end
        return;
      end
      PhOnset: begin
        if (k == ClsClusterCons) begin
          syl_end     = consumed;
          has_cluster = 1'b1;
          phase       = PhMarks;
          return;
        end
        phase = PhMarks;
      end
      PhMarks: ;
      PhDone: return;
      default: begin
        phase = PhInvalid;
        return;
      end
    endcase
    case (k)
      ClsNull: phase = PhInvalid;
      ClsMark: syl_end = consumed;
      ClsSpacingVowel: begin
        syl_end   = consumed;
        has_vowel = 1'b1;
      end
      default: begin
        // A cluster letter closes the syllable only when a cluster was seen.
        if (!has_vowel &&
            (k == ClsPlainCons || (k == ClsClusterCons && has_cluster))) begin
          syl_end = consumed;
        end
        phase = PhDone;
      end
    endcase
  endfunction

  function automatic void feed_byte(logic [7:0] b, logic is_last);
    syl_len_t    r;
    int unsigned len;
    if (phase != PhDone && phase != PhInvalid) begin
      if (consumed <= MAX_BYTES) consumed++;
      if (cont_left == 0) begin
        if (!b[7]) begin
          parse_codepoint(cp_t'(b));
        end else if (b[7:5] == 3'b110) begin
          partial_cp = cp_t'(b[4:0]);
          cont_left  = 1;
        end else if (b[7:4] == 4'b1110) begin
          partial_cp = cp_t'(b[3:0]);
          cont_left  = 2;
        end else if (b[7:3] == 5'b11110) begin
          partial_cp = cp_t'(b[2:0]);
          cont_left  = 3;
        end else begin
          parse_codepoint('0);
        end
      end else if (b[7:6] != 2'b10) begin
        cont_left  = 0;
        partial_cp = '0;
        parse_codepoint('0);
      end else begin
        partial_cp = {partial_cp[CpW-7:0], b[5:0]};
        cont_left--;
        if (cont_left == 0) parse_codepoint(partial_cp);
      end
    end
    if (is_last) begin
      len = (phase == PhOnset || phase == PhMarks || phase == PhDone) ? syl_end : 0;
      r.too_long = (len > MAX_BYTES);
      r.nbytes   = r.too_long ? SylW'(MAX_BYTES) : SylW'(len);
      syl_len_q.push_back(r);
      clear_parse();
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    syl_len_t want;
    if (!rst_ni) begin
      clear_parse();
      syl_len_q.delete();
      pending_o    = 0;
      mismatches_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (syl_len_q.size() == 0) begin
          mismatches_o++;
          $display("%0t: unexpected result item: expected none, got length %0d too_long %0b",
                   $time, syllable_bytes_i, too_long_i);
        end else begin
          want = syl_len_q.pop_front();
          if (syllable_bytes_i !== want.nbytes) begin
            mismatches_o++;
            $display("%0t: syllable_bytes expected %0d, got %0d",
                     $time, want.nbytes, syllable_bytes_i);
          end
          if (too_long_i !== want.too_long) begin
            mismatches_o++;
            $display("%0t: too_long expected %0b, got %0b", $time, want.too_long, too_long_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) feed_byte(byte_value_i, last_byte_i);
      pending_o = syl_len_q.size();
    end
  end

endmodule

FILE: test/thai_syllable_length_finder_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thai syllable length finder testbench
// Sends UTF-8 buffers to the block: directed syllables, malformed and cut-off
// sequences and lengths around the saturation point, then random buffers that
// are mostly well-formed syllables with random content plus some raw noise.
// Both sides pause at random and the receiver holds off now and then so the
// block backs up. The checker module predicts and compares.
// ----------------------------------------------------------------------------
module thai_syllable_length_finder_unit_test;
  import tslf_pkg::*;

  typedef enum logic [2:0] {
    PickLead,
    PickCons,
    PickCluster,
    PickMark,
    PickVowel,
    PickAnyThai,
    PickAscii
  } pick_e;

  logic            clk        = 1'b0;
  logic            rst_n      = 1'b0;
  logic            in_valid   = 1'b0;
  logic [7:0]      byte_value = 8'h00;
  logic            last_byte  = 1'b0;
  logic            out_stall  = 1'b0;
  logic            in_stall;
  logic            out_valid;
  logic [SylW-1:0] syl_bytes;
  logic            too_long;

  int              pending;
  int              mismatches;
  int              send_gap_pct   = 23;
  int              recv_stall_pct = 23;
  bit              hold_req       = 1'b0;
  logic [7:0]      buf_q[$];

  thai_syllable_length_finder_unit #(
    .MAX_BYTES(MaxBytesDflt)
  ) u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .byte_value_i    (byte_value),
    .last_byte_i     (last_byte),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .syllable_bytes_o(syl_bytes),
    .too_long_o      (too_long)
  );

  thai_syllable_length_finder_checker #(
    .MAX_BYTES(MaxBytesDflt)
  ) u_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .byte_value_i    (byte_value),
    .last_byte_i     (last_byte),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .syllable_bytes_i(syl_bytes),
    .too_long_i      (too_long),
    .pending_o       (pending),
    .mismatches_o    (mismatches)
  );

  always #2 clk = ~clk;

  // Encodes one codepoint in the given number of bytes; longer forms than
  // needed are overlong encodings, which the block accepts.
  task automatic push_cp(cp_t c, int nbytes);
    case (nbytes)
      1: buf_q.push_back({1'b0, c[6:0]});
      2: begin
        buf_q.push_back({3'b110, c[10:6]});
        buf_q.push_back({2'b10, c[5:0]});
      end
      3: begin
        buf_q.push_back({4'b1110, c[15:12]});
        buf_q.push_back({2'b10, c[11:6]});
        buf_q.push_back({2'b10, c[5:0]});
      end
      default: begin
        buf_q.push_back({5'b11110, c[20:18]});
        buf_q.push_back({2'b10, c[17:12]});
        buf_q.push_back({2'b10, c[11:6]});
        buf_q.push_back({2'b10, c[5:0]});
      end
    endcase
  endtask

  task automatic add_cp(pick_e k, int nbytes = 0);
    cp_t c;
    int  r;
    r = $urandom_range(15);
    case (k)
      PickLead: c = CpLeadLo + cp_t'(r % 5);
      PickCons: c = CpConsLo + cp_t'($urandom_range(45));
      PickCluster: begin
        case (r % 4)
          0: c = CpClusYo;
          1: c = CpClusRo;
          2: c = CpClusLo;
          default: c = CpClusWo;
        endcase
      end
      PickMark: begin
        if (r == 0) c = CpMarkHan;
        else if (r <= 7) c = CpMarkALo + cp_t'(r - 1);
        else c = CpMarkBLo + cp_t'(r - 8);
      end
      PickVowel: begin
        case (r % 3)
          0: c = CpVowelA;
          1: c = CpVowelAa;
          default: c = CpVowelAm;
        endcase
      end
      PickAnyThai: c = 21'h00E00 + cp_t'($urandom_range(127));
      default: c = cp_t'($urandom_range(127));
    endcase
    if (nbytes == 0) nbytes = (c < 21'h80) ? 1 : (($urandom_range(9) == 0) ? 4 : 3);
    push_cp(c, nbytes);
  endtask

  // Consonant plus marks whose syllable ends exactly at the target length.
  // Four-byte marks take up the remainder modulo three.
  task automatic build_long_syllable(int target);
    int rest;
    int quads;
    rest  = target - 3;
    quads = rest % 3;
    add_cp(PickCons, 3);
    repeat (quads) add_cp(PickMark, 4);
    repeat ((rest - 4 * quads) / 3) add_cp(PickMark, 3);
  endtask

  task automatic send_buffer();
    foreach (buf_q[i]) begin
      while ($urandom_range(99) < send_gap_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid   <= 1'b1;
      byte_value <= buf_q[i];
      last_byte  <= (i == buf_q.size() - 1);
      do @(posedge clk); while (in_stall);
    end
    buf_q.delete();
  endtask

  // Output side: random stalls, and a long hold-off whenever one is asked.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  initial begin : stimulus
    int rand_bytes;
    int nbuf;
    rand_bytes = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single bytes NUL and DEL are not Thai; a lone consonant follows.
    buf_q = '{8'h00};
    send_buffer();
    buf_q = '{8'h7F};
    send_buffer();
    add_cp(PickCons);
    send_buffer();
    // Lead vowel alone never reaches a consonant; with ASCII after it, invalid.
    add_cp(PickLead);
    send_buffer();
    add_cp(PickLead);
    add_cp(PickAscii);
    send_buffer();
    // Lead vowel forbids the coda consonant.
    add_cp(PickLead);
    add_cp(PickCons);
    add_cp(PickMark);
    add_cp(PickVowel);
    add_cp(PickCons);
    send_buffer();
    // Cluster, then a cluster letter as coda, then a trailing consonant.
    add_cp(PickCons);
    add_cp(PickCluster);
    add_cp(PickMark);
    add_cp(PickCluster);
    add_cp(PickCons);
    send_buffer();
    // Without a cluster, a cluster letter after a mark is not a coda.
    add_cp(PickCons);
    add_cp(PickMark);
    add_cp(PickCluster);
    send_buffer();
    add_cp(PickCons);
    add_cp(PickMark);
    add_cp(PickCons);
    send_buffer();
    add_cp(PickCons);
    add_cp(PickVowel);
    add_cp(PickCons);
    send_buffer();
    // A NUL inside the nucleus makes the buffer invalid.
    add_cp(PickCons);
    add_cp(PickMark);
    buf_q.push_back(8'h00);
    send_buffer();
    buf_q = '{8'h80, 8'h41};
    send_buffer();
    buf_q = '{8'hFF};
    send_buffer();
    add_cp(PickCons);
    buf_q.push_back(8'hF8);
    send_buffer();
    // Missing continuation byte.
    add_cp(PickCons);
    buf_q.push_back(8'hE0);
    buf_q.push_back(8'hB8);
    buf_q.push_back(8'h41);
    send_buffer();
    // Cut-off sequences at the end of the buffer are dropped.
    add_cp(PickCons);
    buf_q.push_back(8'hE0);
    buf_q.push_back(8'hB8);
    send_buffer();
    add_cp(PickCons);
    add_cp(PickMark);
    buf_q.push_back(8'hF0);
    buf_q.push_back(8'h80);
    buf_q.push_back(8'hB8);
    send_buffer();
    // Overlong NUL and overlong ASCII, then an overlong consonant and mark.
    push_cp('0, 2);
    send_buffer();
    push_cp(21'h41, 2);
    send_buffer();
    push_cp(CpConsLo, 4);
    add_cp(PickMark, 4);
    send_buffer();
    // Bytes after the syllable is decided are ignored, garbage included.
    add_cp(PickCons);
    add_cp(PickMark);
    add_cp(PickAscii);
    buf_q.push_back(8'hFF);
    buf_q.push_back(8'h80);
    send_buffer();
    buf_q = '{8'h41};
    add_cp(PickCons);
    send_buffer();
    // Lengths at and past the saturation point.
    build_long_syllable(MaxBytesDflt);
    add_cp(PickAscii);
    send_buffer();
    build_long_syllable(MaxBytesDflt + 1);
    send_buffer();
    build_long_syllable(MaxBytesDflt - 5);
    repeat (4) add_cp(PickMark, 3);
    add_cp(PickAscii);
    send_buffer();

    for (nbuf = 0; rand_bytes < 1100; nbuf++) begin
      send_gap_pct   = (nbuf >= 35 && nbuf < 65) ? 0 : 23;
      recv_stall_pct = send_gap_pct;
      if (nbuf == 20 || nbuf == 72) hold_req = 1'b1;
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 8)) buf_q.push_back(8'($urandom));
      end else begin
        if ($urandom_range(2) == 0) add_cp(PickLead);
        add_cp(PickCons);
        if ($urandom_range(2) == 0) add_cp(PickCluster);
        repeat ($urandom_range(3)) begin
          if ($urandom_range(1) == 0) add_cp(PickMark);
          else add_cp(PickVowel);
        end
        case ($urandom_range(4))
          0: add_cp(PickCons);
          1: add_cp(PickCluster);
          2: add_cp(PickAscii);
          3: add_cp(PickAnyThai);
          default: ;
        endcase
        repeat ($urandom_range(3)) begin
          if ($urandom_range(1) == 0) add_cp(PickAnyThai);
          else add_cp(PickAscii);
        end
        case ($urandom_range(7))
          0: buf_q[$urandom_range(buf_q.size() - 1)] = 8'($urandom);
          1: repeat ($urandom_range(1, 2)) void'(buf_q.pop_back());
          default: ;
        endcase
        if (buf_q.size() == 0) buf_q.push_back(8'($urandom));
      end
      rand_bytes += buf_q.size();
      send_buffer();
    end
    in_valid <= 1'b0;

    for (int n = 0; n < 4000 && pending != 0; n++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
